@@ rtl/bsm_pkg.sv @@
// Shared types and constants for the bank switch mapper.
package bsm_pkg;

  localparam int unsigned CHAR_WINDOWS = 8;
  localparam int unsigned PROG_WINDOWS = 4;
  localparam int unsigned CHAR_IDX_W   = $clog2(CHAR_WINDOWS);
  localparam int unsigned PROG_IDX_W   = $clog2(PROG_WINDOWS);

  // Bus event kinds
  typedef enum logic [1:0] {
    OP_CPU_WRITE  = 2'd0,
    OP_TICK       = 2'd1,
    OP_CPU_LOOKUP = 2'd2,
    OP_PPU_LOOKUP = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic CFG_LAST_PRG_BANK     = 1'b0;
  localparam logic CFG_INITIAL_MIRRORING = 1'b1;

  // Command register codes (0-7 are character banks)
  localparam logic [3:0] CMD_PRG0     = 4'd8;
  localparam logic [3:0] CMD_PRG1     = 4'd9;
  localparam logic [3:0] CMD_PRG2     = 4'd10;
  localparam logic [3:0] CMD_PRG3     = 4'd11;
  localparam logic [3:0] CMD_MIRROR   = 4'd12;
  localparam logic [3:0] CMD_IRQ_CTRL = 4'd13;
  localparam logic [3:0] CMD_CNT_LO   = 4'd14;
  localparam logic [3:0] CMD_CNT_HI   = 4'd15;

  // CPU address regions, by address bits 15:13 (write selects by bits 14:13)
  localparam logic [2:0] CPU_RAM_WIN  = 3'd3;   // 6000h-7FFFh
  localparam logic [2:0] CPU_FIXED    = 3'd7;   // E000h-FFFFh
  localparam logic [1:0] WR_CMD_SEL   = 2'd0;   // 8000h-9FFFh
  localparam logic [1:0] WR_CMD_LOAD  = 2'd1;   // A000h-BFFFh

  // Mapping state seen by the lookup logic
  typedef struct packed {
    logic [CHAR_WINDOWS-1:0][7:0] char_banks;
    logic [PROG_WINDOWS-1:0][7:0] prog_banks;
    logic [7:0]                   last_prg_bank;
    logic                         ram_mapped;
    logic                         ram_enabled;
    logic [1:0]                   mirror_mode;
    logic                         irq_pending;
  } map_view_t;

endpackage

@@ rtl/bsm_state.sv @@
// Mapper register file: command writes, IRQ counter and configuration.
module bsm_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  bsm_pkg::op_e        opcode_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output bsm_pkg::map_view_t  view_o
);

  logic [3:0]                                    cmd_q, cmd_d;
  logic [bsm_pkg::CHAR_WINDOWS-1:0][7:0]         chr_q, chr_d;
  logic [bsm_pkg::PROG_WINDOWS-1:0][7:0]         prg_q, prg_d;
  logic [7:0]                                    last_q, last_d;
  logic                                          init_mir_q, init_mir_d;
  logic                                          ram_map_q, ram_map_d;
  logic                                          ram_en_q, ram_en_d;
  logic [1:0]                                    mir_q, mir_d;
  logic                                          irq_en_q, irq_en_d;
  logic                                          cnt_en_q, cnt_en_d;
  logic [15:0]                                   cnt_q, cnt_d;
  logic                                          irq_q, irq_d;

  // Next state for one bus event or a configuration write
  always_comb begin
    cmd_d      = cmd_q;
    chr_d      = chr_q;
    prg_d      = prg_q;
    last_d     = last_q;
    init_mir_d = init_mir_q;
    ram_map_d  = ram_map_q;
    ram_en_d   = ram_en_q;
    mir_d      = mir_q;
    irq_en_d   = irq_en_q;
    cnt_en_d   = cnt_en_q;
    cnt_d      = cnt_q;
    irq_d      = irq_q;

    if (step_en_i) begin
      case (opcode_i)
        bsm_pkg::OP_CPU_WRITE: begin
          if (address_i[15]) begin
            if (address_i[14:13] == bsm_pkg::WR_CMD_SEL) begin
              cmd_d = data_i[3:0];
            end else if (address_i[14:13] == bsm_pkg::WR_CMD_LOAD) begin
              case (cmd_q) inside
                [4'd0:4'd7]: chr_d[cmd_q[bsm_pkg::CHAR_IDX_W-1:0]] = data_i;
                bsm_pkg::CMD_PRG0: begin
                  prg_d[0]  = data_i;
                  ram_map_d = data_i[6];
                  ram_en_d  = data_i[7];
                end
                bsm_pkg::CMD_PRG1, bsm_pkg::CMD_PRG2, bsm_pkg::CMD_PRG3:
                  prg_d[cmd_q[bsm_pkg::PROG_IDX_W-1:0]] = data_i;
                bsm_pkg::CMD_MIRROR: mir_d = data_i[1:0];
                bsm_pkg::CMD_IRQ_CTRL: begin
                  irq_en_d = data_i[0];
                  cnt_en_d = data_i[7];
                  irq_d    = 1'b0;
                end
                bsm_pkg::CMD_CNT_LO: cnt_d[7:0] = data_i;
                default: cnt_d[15:8] = data_i;
              endcase
            end
          end
        end
        bsm_pkg::OP_TICK: begin
          // decrement; IRQ on wrap to FFFFh
          if (cnt_en_q) begin
            cnt_d = cnt_q - 16'd1;
            if ((cnt_q == 16'd0) && irq_en_q) begin
              irq_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // Configuration writes must arrive only while idle; this block does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsm_pkg::CFG_LAST_PRG_BANK: last_d = cfg_data_i;
        default: begin
          init_mir_d = cfg_data_i[0];
          mir_d      = {1'b0, cfg_data_i[0]};
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= '0;
      chr_q      <= '0;
      for (int i = 0; i < bsm_pkg::PROG_WINDOWS; i++) begin
        prg_q[i] <= 8'(i);
      end
      last_q     <= 8'hFF;
      init_mir_q <= 1'b0;
      ram_map_q  <= 1'b0;
      ram_en_q   <= 1'b0;
      mir_q      <= 2'd0;
      irq_en_q   <= 1'b0;
      cnt_en_q   <= 1'b0;
      cnt_q      <= '0;
      irq_q      <= 1'b0;
    end else begin
      cmd_q      <= cmd_d;
      chr_q      <= chr_d;
      prg_q      <= prg_d;
      last_q     <= last_d;
      init_mir_q <= init_mir_d;
      ram_map_q  <= ram_map_d;
      ram_en_q   <= ram_en_d;
      mir_q      <= mir_d;
      irq_en_q   <= irq_en_d;
      cnt_en_q   <= cnt_en_d;
      cnt_q      <= cnt_d;
      irq_q      <= irq_d;
    end
  end

  // Post-event view; lookups leave the state unchanged
  assign view_o.char_banks    = chr_d;
  assign view_o.prog_banks    = prg_d;
  assign view_o.last_prg_bank = last_d;
  assign view_o.ram_mapped    = ram_map_d;
  assign view_o.ram_enabled   = ram_en_d;
  assign view_o.mirror_mode   = mir_d;
  assign view_o.irq_pending   = irq_d;

endmodule

@@ rtl/bsm_lookup.sv @@
// Address decode for CPU and PPU bank lookups.
module bsm_lookup (
  input  bsm_pkg::op_e        opcode_i,
  input  logic [15:0]         address_i,
  input  bsm_pkg::map_view_t  view_i,
  output logic [7:0]          bank_o,
  output logic                ram_select_o,
  output logic                mapped_o
);

  logic [bsm_pkg::PROG_IDX_W-1:0] prg_idx;
  logic [2:0]                     prg_off;

  // Program window index counted from 6000h
  assign prg_off = address_i[15:13] - bsm_pkg::CPU_RAM_WIN;
  assign prg_idx = prg_off[bsm_pkg::PROG_IDX_W-1:0];

  always_comb begin
    bank_o       = 8'd0;
    ram_select_o = 1'b0;
    mapped_o     = 1'b0;
    case (opcode_i)
      bsm_pkg::OP_CPU_LOOKUP: begin
        if (address_i[15:13] >= bsm_pkg::CPU_RAM_WIN) begin
          mapped_o = 1'b1;
          if (address_i[15:13] == bsm_pkg::CPU_FIXED) begin
            bank_o = view_i.last_prg_bank;
          end else if (address_i[15:13] == bsm_pkg::CPU_RAM_WIN) begin
            if (view_i.ram_mapped && view_i.ram_enabled) begin
              ram_select_o = 1'b1;
            end else begin
              bank_o = view_i.prog_banks[0];
            end
          end else begin
            bank_o = view_i.prog_banks[prg_idx];
          end
        end
      end
      bsm_pkg::OP_PPU_LOOKUP: begin
        if (address_i[15:13] == 3'd0) begin
          mapped_o = 1'b1;
          bank_o   = view_i.char_banks[address_i[12:10]];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bank_switch_mapper_with_irq_counter.sv @@
// Top level of the bank switch mapper with tick-event IRQ counter.
//
//  channel  | handshake                 | word
//  ---------+---------------------------+------------------------------------
//  in       | in_valid_i / in_ready_o   | opcode_i, address_i, data_i
//  out      | out_valid_o / out_ready_i | bank_o, ram_select_o, mapped_o,
//           |                           | mirroring_o, irq_line_o
//  cfg      | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_ready_i is high; each word goes
// through the input register, then decode and state update into the
// result register. The state updates when a word moves from the input
// register into the result register. A stalled result register holds the
// input register, and in_ready_o drops only when both are full.
// Reset is asynchronous and returns all mapper state to its reset values.
module bank_switch_mapper_with_irq_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  bank_o,
  output logic        ram_select_o,
  output logic        mapped_o,
  output logic [1:0]  mirroring_o,
  output logic        irq_line_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic               in_vld_q;
  bsm_pkg::op_e       op_q;
  logic [15:0]        addr_q;
  logic [7:0]         data_q;
  logic               out_vld_q;
  logic [7:0]         bank_q;
  logic               ram_q;
  logic               mapped_q;
  logic [1:0]         mir_q;
  logic               irq_q;
  logic               advance;
  bsm_pkg::map_view_t view;
  logic [7:0]         bank_d;
  logic               ram_d;
  logic               mapped_d;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= bsm_pkg::op_e'(opcode_i);
      addr_q <= address_i;
      data_q <= data_i;
    end
  end

  bsm_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (advance),
    .opcode_i    (op_q),
    .address_i   (addr_q),
    .data_i      (data_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .view_o      (view)
  );

  bsm_lookup u_lookup (
    .opcode_i     (op_q),
    .address_i    (addr_q),
    .view_i       (view),
    .bank_o       (bank_d),
    .ram_select_o (ram_d),
    .mapped_o     (mapped_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bank_q   <= bank_d;
      ram_q    <= ram_d;
      mapped_q <= mapped_d;
      mir_q    <= view.mirror_mode;
      irq_q    <= view.irq_pending;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign bank_o       = bank_q;
  assign ram_select_o = ram_q;
  assign mapped_o     = mapped_q;
  assign mirroring_o  = mir_q;
  assign irq_line_o   = irq_q;

endmodule
